### design/gregorian_date_add_days_assert.svh
// Assertion macros shared by the date adder RTL.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDAD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/gdad_pkg.sv
// Shared types, constants and the month length table of the date adder.
// Used by gdad_month_unit and gregorian_date_add_days; depends on nothing.
package gdad_pkg;

    localparam int ADD_W        = 16;
    localparam int ADD_BITS_DEF = 16;
    localparam int DAY_IN_W     = 5;
    localparam int MON_W        = 4;
    localparam int YEAR_W       = 14;

    localparam logic [YEAR_W-1:0] FIRST_YEAR = 14'd1601;
    localparam logic [YEAR_W-1:0] LAST_YEAR  = 14'd9999;
    localparam logic [MON_W-1:0]  MONTHS     = 4'd12;
    localparam logic [MON_W-1:0]  FEBRUARY   = 4'd2;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit year.
    localparam int              RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int              RECIP_SHIFT = 19;
    localparam int              PROD_W      = YEAR_W + RECIP_W;
    localparam int              CENT_W      = PROD_W - RECIP_SHIFT;
    localparam int              MOD_W       = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MOD,
        S_CHK,
        S_LOOP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             over;
        logic             wrap;
        logic [MON_W-1:0] month_nx;
    } t_step;

    // Length of a month; zero for a month code outside 1 to 12.
    function automatic logic [DAY_IN_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                      input logic leap);
        logic [DAY_IN_W-1:0] len;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
                4'd2:                                      len = leap ? 5'd29 : 5'd28;
                default:                                   len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

### design/gdad_month_unit.sv
// Shared compare and subtract unit: tests the day count against the month
// length and forms the remaining days and the following month. Uses gdad_pkg.
module gdad_month_unit #(
    parameter int ADD_BITS = gdad_pkg::ADD_BITS_DEF
) (
    input  logic [((ADD_BITS < gdad_pkg::ADD_W) ? ADD_BITS : gdad_pkg::ADD_W):0] i_day,
    input  logic [gdad_pkg::MON_W-1:0] i_month,
    input  logic                       i_leap,
    output logic [((ADD_BITS < gdad_pkg::ADD_W) ? ADD_BITS : gdad_pkg::ADD_W):0] o_diff,
    output gdad_pkg::t_step            o_step
);

    localparam int USED_W = (ADD_BITS < gdad_pkg::ADD_W) ? ADD_BITS : gdad_pkg::ADD_W;
    localparam int DAY_W  = USED_W + 1;

    logic [DAY_W-1:0] w_len;

    assign w_len  = DAY_W'(gdad_pkg::month_len(i_month, i_leap));
    assign o_diff = i_day - w_len;

    always_comb begin
        o_step.over     = (i_day > w_len);
        o_step.wrap     = (i_month >= gdad_pkg::MONTHS);
        o_step.month_nx = o_step.wrap ? 4'd1 : (i_month + 4'd1);
    end

endmodule

### design/gregorian_date_add_days.sv
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     start_day, start_month, start_year, days_to_add
// output    out        o_out_valid / i_out_stall   result_day/month/year, date_valid, year_overflow
//
// A valid date passes S_MUL, S_MOD and S_CHK, then stays in S_LOOP until no month boundary
// is left or the year overflows, and ends in S_DONE; an invalid date goes from S_CHK to S_DONE.
// The input stalls while a word is in progress; a finished result waits in the
// output register, so the next word can be taken while it is held by a stall.
// Reset is synchronous, active low, and clears the sequencer and output valid.
// Depends on gdad_pkg, gdad_month_unit and gregorian_date_add_days_assert.svh.
`include "gregorian_date_add_days_assert.svh"

module gregorian_date_add_days #(
    parameter int ADD_BITS = gdad_pkg::ADD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gdad_pkg::DAY_IN_W-1:0] i_start_day,
    input  logic [gdad_pkg::MON_W-1:0]    i_start_month,
    input  logic [gdad_pkg::YEAR_W-1:0]   i_start_year,
    input  logic [gdad_pkg::ADD_W-1:0]    i_days_to_add,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gdad_pkg::DAY_IN_W-1:0] o_result_day,
    output logic [gdad_pkg::MON_W-1:0]    o_result_month,
    output logic [gdad_pkg::YEAR_W-1:0]   o_result_year,
    output logic                          o_date_valid,
    output logic                          o_year_overflow
);

    localparam int USED_W = (ADD_BITS < gdad_pkg::ADD_W) ? ADD_BITS : gdad_pkg::ADD_W;
    localparam int DAY_W  = USED_W + 1;

    gdad_pkg::t_state r_state, n_state;

    logic [DAY_W-1:0]               r_day;
    logic [USED_W-1:0]              r_add;
    logic [gdad_pkg::MON_W-1:0]     r_month;
    logic [gdad_pkg::YEAR_W-1:0]    r_year;
    logic [gdad_pkg::PROD_W-1:0]    r_prod;
    logic [gdad_pkg::MOD_W-1:0]     r_mod100;
    logic [1:0]                     r_cent;
    logic                           r_dvalid;
    logic                           r_ovf;

    logic                           r_ov;
    logic [gdad_pkg::DAY_IN_W-1:0]  r_o_day;
    logic [gdad_pkg::MON_W-1:0]     r_o_month;
    logic [gdad_pkg::YEAR_W-1:0]    r_o_year;
    logic                           r_o_dvalid;
    logic                           r_o_ovf;

    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_load;
    logic                           w_leap;
    logic                           w_start_ok;
    logic [gdad_pkg::CENT_W-1:0]    w_cent;
    logic [gdad_pkg::YEAR_W:0]      w_mod_full;
    logic [DAY_W-1:0]               w_diff;
    gdad_pkg::t_step                w_step;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ov || !i_out_stall;

    // Year mod 100 comes from the reciprocal product; the century count's low
    // two bits decide the 400-year rule.
    assign w_cent     = r_prod[gdad_pkg::PROD_W-1:gdad_pkg::RECIP_SHIFT];
    assign w_mod_full = (gdad_pkg::YEAR_W+1)'(r_year)
                      - (gdad_pkg::YEAR_W+1)'(w_cent) * (gdad_pkg::YEAR_W+1)'(100);
    assign w_leap     = (r_year[1:0] == 2'd0) && ((r_mod100 != '0) || (r_cent == 2'd0));

    gdad_month_unit #(
        .ADD_BITS (ADD_BITS)
    ) u_month (
        .i_day   (r_day),
        .i_month (r_month),
        .i_leap  (w_leap),
        .o_diff  (w_diff),
        .o_step  (w_step)
    );

    assign w_start_ok = (r_year >= gdad_pkg::FIRST_YEAR) && (r_month >= 4'd1)
                     && (r_month <= gdad_pkg::MONTHS) && (r_day != '0) && !w_step.over;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gdad_pkg::S_IDLE: if (i_in_valid) n_state = gdad_pkg::S_MUL;
            gdad_pkg::S_MUL:  n_state = gdad_pkg::S_MOD;
            gdad_pkg::S_MOD:  n_state = gdad_pkg::S_CHK;
            gdad_pkg::S_CHK:  n_state = w_start_ok ? gdad_pkg::S_LOOP : gdad_pkg::S_DONE;
            gdad_pkg::S_LOOP: begin
                if (!w_step.over || (w_step.wrap && r_year >= gdad_pkg::LAST_YEAR)) begin
                    n_state = gdad_pkg::S_DONE;
                end
            end
            gdad_pkg::S_DONE: if (w_out_free) n_state = gdad_pkg::S_IDLE;
            default:          n_state = gdad_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_load     = 1'b0;
        case (r_state)
            gdad_pkg::S_IDLE: o_in_stall = 1'b0;
            gdad_pkg::S_DONE: w_load     = w_out_free;
            default: begin
                o_in_stall = 1'b1;
                w_load     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdad_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            gdad_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_day    <= DAY_W'(i_start_day);
                    r_month  <= i_start_month;
                    r_year   <= i_start_year;
                    r_add    <= i_days_to_add[USED_W-1:0];
                    r_dvalid <= 1'b0;
                    r_ovf    <= 1'b0;
                end
            end
            gdad_pkg::S_MUL: begin
                r_prod <= gdad_pkg::PROD_W'(r_year) * gdad_pkg::PROD_W'(gdad_pkg::RECIP_100);
            end
            gdad_pkg::S_MOD: begin
                r_mod100 <= w_mod_full[gdad_pkg::MOD_W-1:0];
                r_cent   <= w_cent[1:0];
            end
            gdad_pkg::S_CHK: begin
                if (w_start_ok) begin
                    r_day    <= r_day + DAY_W'(r_add);
                    r_dvalid <= 1'b1;
                end
            end
            gdad_pkg::S_LOOP: begin
                if (w_step.over) begin
                    if (w_step.wrap && r_year >= gdad_pkg::LAST_YEAR) begin
                        r_ovf   <= 1'b1;
                        r_day   <= DAY_W'(31);
                        r_month <= gdad_pkg::MONTHS;
                        r_year  <= gdad_pkg::LAST_YEAR;
                    end else begin
                        r_day   <= w_diff;
                        r_month <= w_step.month_nx;
                        if (w_step.wrap) begin
                            r_year <= r_year + 14'd1;
                            if (r_mod100 == 7'd99) begin
                                r_mod100 <= '0;
                                r_cent   <= r_cent + 2'd1;
                            end else begin
                                r_mod100 <= r_mod100 + 7'd1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_day    <= r_day[gdad_pkg::DAY_IN_W-1:0];
            r_o_month  <= r_month;
            r_o_year   <= r_year;
            r_o_dvalid <= r_dvalid;
            r_o_ovf    <= r_ovf;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_result_day    = r_o_day;
    assign o_result_month  = r_o_month;
    assign o_result_year   = r_o_year;
    assign o_date_valid    = r_o_dvalid;
    assign o_year_overflow = r_o_ovf;

    `GDAD_ASSERT_NEXT(a_accept_starts, w_accept, r_state == gdad_pkg::S_MUL, "accepted word did not start")
    `GDAD_ASSERT_NOW(a_loop_month, r_state == gdad_pkg::S_LOOP, (r_month >= 4'd1) && (r_month <= gdad_pkg::MONTHS), "month out of range in loop")
    `GDAD_ASSERT_NOW(a_loop_mod, r_state == gdad_pkg::S_LOOP, r_mod100 < 7'd100, "year mod 100 tracker out of range")
    `GDAD_ASSERT_NOW(a_ovf_valid, r_ov && o_year_overflow, o_date_valid && (o_result_year == gdad_pkg::LAST_YEAR), "overflow result not saturated")

endmodule

### tb/testbench.sv
// Self-checking testbench for gregorian_date_add_days: directed table, then random date words.
// Results are checked against typed rows or a behavioral date adder kept here; depends on gdad_pkg and the RTL.
module testbench;

    localparam int ADD_BITS   = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 600;
    localparam int RANDOM_WORDS = 250;
    localparam int N_DIRECTED = 21;

    typedef struct packed {
        logic [gdad_pkg::DAY_IN_W-1:0] day;
        logic [gdad_pkg::MON_W-1:0]    month;
        logic [gdad_pkg::YEAR_W-1:0]   year;
        logic [gdad_pkg::ADD_W-1:0]    add;
    } t_date_in;

    typedef struct packed {
        logic [gdad_pkg::DAY_IN_W-1:0] day;
        logic [gdad_pkg::MON_W-1:0]    month;
        logic [gdad_pkg::YEAR_W-1:0]   year;
        logic                          valid;
        logic                          ovf;
    } t_date_out;

    typedef struct packed {
        t_date_in  word;
        logic      typed;
        t_date_out want;
    } t_row;

    // Rows with typed = 1 carry an expectation read straight off the rules.
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{'{5'd0,  4'd1,  14'd2000,  16'd5},     1'b1, '{5'd0,  4'd1,  14'd2000,  1'b0, 1'b0}},
        '{'{5'd31, 4'd15, 14'd16383, 16'd65535}, 1'b1, '{5'd31, 4'd15, 14'd16383, 1'b0, 1'b0}},
        '{'{5'd1,  4'd1,  14'd1600,  16'd10},    1'b1, '{5'd1,  4'd1,  14'd1600,  1'b0, 1'b0}},
        '{'{5'd29, 4'd2,  14'd1900,  16'd1},     1'b1, '{5'd29, 4'd2,  14'd1900,  1'b0, 1'b0}},
        '{'{5'd29, 4'd2,  14'd2000,  16'd0},     1'b1, '{5'd29, 4'd2,  14'd2000,  1'b1, 1'b0}},
        '{'{5'd31, 4'd12, 14'd9999,  16'd1},     1'b1, '{5'd31, 4'd12, 14'd9999,  1'b1, 1'b1}},
        '{'{5'd1,  4'd1,  14'd1601,  16'd0},     1'b1, '{5'd1,  4'd1,  14'd1601,  1'b1, 1'b0}},
        '{'{5'd31, 4'd12, 14'd9999,  16'd0},     1'b1, '{5'd31, 4'd12, 14'd9999,  1'b1, 1'b0}},
        '{'{5'd1,  4'd1,  14'd16383, 16'd0},     1'b1, '{5'd1,  4'd1,  14'd16383, 1'b1, 1'b0}},
        '{'{5'd1,  4'd12, 14'd16383, 16'd31},    1'b1, '{5'd31, 4'd12, 14'd9999,  1'b1, 1'b1}},
        '{'{5'd0,  4'd0,  14'd0,     16'd0},     1'b1, '{5'd0,  4'd0,  14'd0,     1'b0, 1'b0}},
        '{'{5'd31, 4'd4,  14'd2020,  16'd3},     1'b1, '{5'd31, 4'd4,  14'd2020,  1'b0, 1'b0}},
        '{'{5'd1,  4'd13, 14'd2000,  16'd3},     1'b1, '{5'd1,  4'd13, 14'd2000,  1'b0, 1'b0}},
        '{'{5'd1,  4'd1,  14'd10000, 16'd40},    1'b0, '0},
        '{'{5'd28, 4'd2,  14'd2024,  16'd1},     1'b0, '0},
        '{'{5'd28, 4'd2,  14'd2100,  16'd1},     1'b0, '0},
        '{'{5'd1,  4'd1,  14'd1601,  16'd65535}, 1'b0, '0},
        '{'{5'd31, 4'd1,  14'd2001,  16'd65535}, 1'b0, '0},
        '{'{5'd15, 4'd6,  14'd9990,  16'd65535}, 1'b0, '0},
        '{'{5'd30, 4'd4,  14'd2020,  16'd65535}, 1'b0, '0},
        '{'{5'd29, 4'd2,  14'd2400,  16'd365},   1'b0, '0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [gdad_pkg::DAY_IN_W-1:0] start_day = '0;
    logic [gdad_pkg::MON_W-1:0]    start_month = '0;
    logic [gdad_pkg::YEAR_W-1:0]   start_year = '0;
    logic [gdad_pkg::ADD_W-1:0]    days_to_add = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [gdad_pkg::DAY_IN_W-1:0] result_day;
    logic [gdad_pkg::MON_W-1:0]    result_month;
    logic [gdad_pkg::YEAR_W-1:0]   result_year;
    logic                          date_valid;
    logic                          year_overflow;

    t_row      stim_q[$];
    t_date_out pending_dates[$];
    int        mismatch_count = 0;
    int        results_seen = 0;
    int        idle_cycles = 0;

    gregorian_date_add_days #(.ADD_BITS(ADD_BITS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_start_day    (start_day),
        .i_start_month  (start_month),
        .i_start_year   (start_year),
        .i_days_to_add  (days_to_add),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_day   (result_day),
        .o_result_month (result_month),
        .o_result_year  (result_year),
        .o_date_valid   (date_valid),
        .o_year_overflow(year_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int days_in_month(int m, int y);
        bit leap_year;
        int len;
        leap_year = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_year ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic t_date_out add_days_to_date(t_date_in w);
        int        d;
        int        m;
        int        y;
        int        len;
        bit        ovf;
        bit        busy;
        t_date_out r;
        d = w.day;
        m = w.month;
        y = w.year;
        ovf = 1'b0;
        if (y < gdad_pkg::FIRST_YEAR || m < 1 || m > gdad_pkg::MONTHS || d < 1
            || d > days_in_month(m, y)) begin
            r = '{w.day, w.month, w.year, 1'b0, 1'b0};
            return r;
        end
        d = d + (int'(w.add) & ((1 << ADD_BITS) - 1));
        busy = 1'b1;
        while (busy) begin
            len = days_in_month(m, y);
            if (d <= len) begin
                busy = 1'b0;
            end else begin
                d = d - len;
                m = m + 1;
                if (m > gdad_pkg::MONTHS) begin
                    m = 1;
                    // The carry stops at the last year, even for a start year above it.
                    if (y >= gdad_pkg::LAST_YEAR) begin
                        ovf = 1'b1;
                        busy = 1'b0;
                    end else begin
                        y = y + 1;
                    end
                end
            end
        end
        if (ovf) begin
            d = 31;
            m = 12;
            y = gdad_pkg::LAST_YEAR;
        end
        r = '{gdad_pkg::DAY_IN_W'(d), gdad_pkg::MON_W'(m), gdad_pkg::YEAR_W'(y), 1'b1, ovf};
        return r;
    endfunction

    // Mostly well-formed dates; some words have every field drawn at random.
    function automatic t_date_in make_random_word();
        t_date_in w;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            w.day = gdad_pkg::DAY_IN_W'($urandom);
            w.month = gdad_pkg::MON_W'($urandom);
            w.year = gdad_pkg::YEAR_W'($urandom_range(0, 16383));
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 70) w.year = gdad_pkg::YEAR_W'($urandom_range(1601, 9999));
            else if (sel < 85) w.year = gdad_pkg::YEAR_W'($urandom_range(9900, 9999));
            else w.year = gdad_pkg::YEAR_W'($urandom_range(10000, 16383));
            w.month = gdad_pkg::MON_W'($urandom_range(1, 12));
            w.day = gdad_pkg::DAY_IN_W'($urandom_range(1, days_in_month(w.month, w.year)));
        end
        sel = $urandom_range(0, 99);
        if (sel < 60) w.add = gdad_pkg::ADD_W'($urandom_range(0, 400));
        else if (sel < 88) w.add = gdad_pkg::ADD_W'($urandom_range(0, 5000));
        else w.add = gdad_pkg::ADD_W'($urandom);
        return w;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 100);
    endfunction

    // Sender: one word at a time, with random gaps and gap-free bursts.
    initial begin
        t_row row;
        int   gap;
        for (int i = 0; i < N_DIRECTED; i++) stim_q.push_back(DIRECTED[i]);
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            row.word = make_random_word();
            row.typed = 1'b0;
            row.want = '0;
            stim_q.push_back(row);
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < stim_q.size(); i++) begin
            row = stim_q[i];
            gap = ((i / 30) % 3 == 2) ? 0 : pick_gap();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            start_day <= row.word.day;
            start_month <= row.word.month;
            start_year <= row.word.year;
            days_to_add <= row.word.add;
            in_valid <= 1'b1;
            do @(posedge i_clk); while (in_stall);
            pending_dates.push_back(row.typed ? row.want : add_days_to_date(row.word));
            @(negedge i_clk);
        end
        in_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && pending_dates.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver: random stalls, free stretches, and one long hold-off that backs up the block.
    initial begin
        int  stall_left;
        int  free_left;
        bit  held;
        stall_left = 0;
        free_left = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 60) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (free_left > 0) begin
                free_left--;
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                free_left = $urandom_range(30, 200);
                out_stall <= 1'b0;
            end else begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        t_date_out got;
        t_date_out exp_date;
        if (i_rst_n && out_valid && !out_stall) begin
            got = '{result_day, result_month, result_year, date_valid, year_overflow};
            results_seen <= results_seen + 1;
            if (pending_dates.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) begin
                    $display("unexpected result word: %0d/%0d/%0d valid %0b ovf %0b",
                             got.day, got.month, got.year, got.valid, got.ovf);
                end
            end else begin
                exp_date = pending_dates.pop_front();
                if (got !== exp_date) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) begin
                        $display("mismatch: expected %0d/%0d/%0d valid %0b ovf %0b, got %0d/%0d/%0d valid %0b ovf %0b",
                                 exp_date.day, exp_date.month, exp_date.year,
                                 exp_date.valid, exp_date.ovf,
                                 got.day, got.month, got.year, got.valid, got.ovf);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
